// ===== hdl/swtm_pkg.sv =====
package swtm_pkg;

    // Field and register widths
    localparam int NOW_W    = 32;
    localparam int BYTES_W  = 31;
    localparam int SUM_W    = 32;
    localparam int RATE_W   = 32;
    localparam int SPAN_W   = 16;
    localparam int BWIDTH_W = 10;
    localparam int WINDOW_W = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 1'b1;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [BWIDTH_W-1:0] BUCKET_WIDTH_RST = 10'd100;
    localparam logic [WINDOW_W-1:0] WINDOW_RST       = 16'd2000;

    // Bucket store depth default
    localparam int MAX_BUCKETS_DEF = 32;

    // Rate scaling and the shared serial divider
    localparam int MS_PER_S_W = 10;
    localparam logic [MS_PER_S_W-1:0] MS_PER_S = 10'd1000;
    localparam int DIV_W      = SUM_W + MS_PER_S_W;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUANT,
        ST_BUCKET,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MULT,
        ST_RATE_GO,
        ST_RATE,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch input beat, start quantizing, read newest bucket
        logic bucket_upd;  // merge into newest bucket or open a new one
        logic rd_scan;     // read the bucket under the scan pointer
        logic scan_step;   // count the bucket just read and step back
        logic mult;        // scale the sum to bytes per second, retire old buckets
        logic div_rate;    // start the rate division
        logic out_load;    // load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic scan_end;
        logic too_old;
        logic span_zero;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ===== hdl/swtm_ctrl.sv =====
module swtm_ctrl
    import swtm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_QUANT;
                end
            end
            ST_QUANT: begin
                if (i_sts.div_done) begin
                    n_state = ST_BUCKET;
                end
            end
            ST_BUCKET: begin
                n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = i_sts.scan_end ? ST_MULT : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                n_state = i_sts.too_old ? ST_MULT : ST_SCAN_RD;
            end
            ST_MULT: begin
                n_state = ST_RATE_GO;
            end
            ST_RATE_GO: begin
                n_state = i_sts.span_zero ? ST_DONE : ST_RATE;
            end
            ST_RATE: begin
                if (i_sts.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_BUCKET: begin
                o_cmd.bucket_upd = 1'b1;
            end
            ST_SCAN_RD: begin
                o_cmd.rd_scan = !i_sts.scan_end;
            end
            ST_SCAN_CHK: begin
                o_cmd.scan_step = !i_sts.too_old;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
            end
            ST_RATE_GO: begin
                o_cmd.div_rate = !i_sts.span_zero;
            end
            ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/swtm_dp.sv =====
module swtm_dp
    import swtm_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input beat fields
    input  logic [NOW_W-1:0]      i_now_ms,
    input  logic [BYTES_W-1:0]    i_byte_count,
    // Result register
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [RATE_W-1:0]     o_bytes_per_second,
    output logic [SUM_W-1:0]      o_window_bytes,
    output logic [SPAN_W-1:0]     o_window_span_ms,
    // Controller link
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_sts             o_sts
);

    localparam int SLOT_W = $clog2(MAX_BUCKETS);
    localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_BUCKETS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_BUCKETS);

    // Configuration registers
    logic [BWIDTH_W-1:0] r_bucket_width;
    logic [WINDOW_W-1:0] r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_width <= BUCKET_WIDTH_RST;
            r_window       <= WINDOW_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BUCKET_WIDTH: r_bucket_width <= i_cfg_data[BWIDTH_W-1:0];
                CFG_WINDOW:       r_window       <= i_cfg_data;
                default:          r_window       <= r_window;
            endcase
        end
    end

    // Bucket store: start times and byte totals, one read and one write port
    logic [NOW_W-1:0] r_mem_start [MAX_BUCKETS];
    logic [SUM_W-1:0] r_mem_bytes [MAX_BUCKETS];
    logic [NOW_W-1:0] r_rd_start;
    logic [SUM_W-1:0] r_rd_bytes;
    logic             mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [NOW_W-1:0]  mem_wstart;
    logic [SUM_W-1:0]  mem_wbytes;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_start[mem_waddr] <= mem_wstart;
            r_mem_bytes[mem_waddr] <= mem_wbytes;
        end
        if (mem_re) begin
            r_rd_start <= r_mem_start[mem_raddr];
            r_rd_bytes <= r_mem_bytes[mem_raddr];
        end
    end

    // Captured input beat
    logic [NOW_W-1:0]   r_now;
    logic [BYTES_W-1:0] r_nbytes;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now    <= i_now_ms;
            r_nbytes <= i_byte_count;
        end
    end

    // Shared restoring divider: one quotient bit per cycle
    logic [DIV_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIVISOR_W:0]   div_trial;
    logic                 div_ge;
    logic [DIV_W-1:0]     r_prod;
    logic [SPAN_W-1:0]    r_span;
    logic [BWIDTH_W-1:0]  width_eff;

    assign width_eff = (r_bucket_width == '0) ? BWIDTH_W'(1) : r_bucket_width;
    assign div_trial = {r_rem, r_quo[DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.capture || i_cmd.div_rate) begin
            r_div_cnt <= DIV_STEPS;
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_quo <= DIV_W'(i_now_ms);
            r_rem <= '0;
            r_dvs <= DIVISOR_W'(width_eff);
        end else if (i_cmd.div_rate) begin
            r_quo <= r_prod;
            r_rem <= '0;
            r_dvs <= r_span;
        end else if (r_div_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], div_ge};
            r_rem <= div_ge ? DIVISOR_W'(div_trial - {1'b0, r_dvs})
                            : div_trial[DIVISOR_W-1:0];
        end
    end

    // Bucket start is the time rounded down to the bucket width
    logic [NOW_W-1:0] bucket_start;
    assign bucket_start = r_now - NOW_W'(r_rem[BWIDTH_W-1:0]);

    // Ring pointers
    logic [SLOT_W-1:0] r_newest;
    logic [CNT_W-1:0]  r_held;
    logic [SLOT_W-1:0] n_newest;
    logic [CNT_W-1:0]  n_held;
    logic              merge;
    logic [SUM_W:0]    merge_sum;

    assign merge     = (r_held != '0) && (r_rd_start == bucket_start);
    assign merge_sum = {1'b0, r_rd_bytes} + (SUM_W + 1)'(r_nbytes);

    always_comb begin
        n_newest = r_newest;
        n_held   = r_held;
        if (!merge) begin
            if (r_held == '0) begin
                n_newest = '0;
            end else if (r_newest == LAST_SLOT) begin
                n_newest = '0;
            end else begin
                n_newest = r_newest + 1'b1;
            end
            if (r_held != FULL_CNT) begin
                n_held = r_held + 1'b1;
            end
        end
    end

    assign mem_we     = i_cmd.bucket_upd;
    assign mem_waddr  = n_newest;
    assign mem_wstart = bucket_start;
    assign mem_wbytes = !merge ? SUM_W'(r_nbytes)
                      : (merge_sum[SUM_W] ? '1 : merge_sum[SUM_W-1:0]);

    // Scan from newest to oldest
    logic [SLOT_W-1:0] r_scan_slot;
    logic [CNT_W-1:0]  r_scan_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [NOW_W-1:0]  age;
    logic [SUM_W:0]    scan_sum;

    assign mem_re    = i_cmd.capture || i_cmd.rd_scan;
    assign mem_raddr = i_cmd.rd_scan ? r_scan_slot : r_newest;
    assign age       = r_now - r_rd_start;
    assign scan_sum  = {1'b0, r_sum} + {1'b0, r_rd_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_held   <= '0;
        end else if (i_cmd.bucket_upd) begin
            r_newest <= n_newest;
            r_held   <= n_held;
        end else if (i_cmd.mult) begin
            r_held   <= r_scan_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bucket_upd) begin
            r_scan_slot <= n_newest;
            r_scan_cnt  <= '0;
            r_sum       <= '0;
            r_span      <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_slot <= (r_scan_slot == '0) ? LAST_SLOT : r_scan_slot - 1'b1;
            r_scan_cnt  <= r_scan_cnt + 1'b1;
            r_sum       <= scan_sum[SUM_W] ? '1 : scan_sum[SUM_W-1:0];
            r_span      <= age[SPAN_W-1:0];
        end
    end

    // Scale the sum to bytes per second ahead of the division
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= DIV_W'(r_sum) * DIV_W'(MS_PER_S);
        end
    end

    // Result register
    logic             r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic [SUM_W-1:0]  r_out_sum;
    logic [SPAN_W-1:0] r_out_span;
    logic [RATE_W-1:0] rate;

    always_comb begin
        if (r_span == '0) begin
            rate = '0;
        end else if (r_quo[DIV_W-1:RATE_W] != '0) begin
            rate = '1;
        end else begin
            rate = r_quo[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rate <= rate;
            r_out_sum  <= r_sum;
            r_out_span <= r_span;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_bytes_per_second = r_out_rate;
    assign o_window_bytes     = r_out_sum;
    assign o_window_span_ms   = r_out_span;

    // Status to the controller
    assign o_sts.div_done  = (r_div_cnt == '0);
    assign o_sts.scan_end  = (r_scan_cnt == r_held);
    assign o_sts.too_old   = (age > NOW_W'(r_window));
    assign o_sts.span_zero = (r_span == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== hdl/sliding_window_throughput_meter_core.sv =====
// Sliding-window throughput meter. Each input beat carries the current time in
// milliseconds and a byte count; the block adds the bytes into a ring of up to
// MAX_BUCKETS time buckets, drops buckets older than the window and returns one
// result beat with the byte sum, the age of the oldest kept bucket and the rate
// in bytes per second. Each item makes two passes through a shared
// one-bit-per-cycle divider of 42 steps each (rounding the time down to the
// bucket width, then the rate division) and a scan of the kept buckets (at
// most MAX_BUCKETS) that reads each bucket from the store and then checks it.
// The rate division is skipped when the span is zero.
// The next beat is taken as soon as the result is in the output register, even
// if that result has not been taken yet. Configuration writes are accepted at
// any time but must only be made while the block is idle.
module sliding_window_throughput_meter_core
    import swtm_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,   // now_ms[31:0], byte_count[62:32]
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata    // bytes_per_second[31:0],
                                                  // window_bytes[63:32],
                                                  // window_span_ms[79:64]
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    logic [RATE_W-1:0] bytes_per_second;
    logic [SUM_W-1:0]  window_bytes;
    logic [SPAN_W-1:0] window_span_ms;

    assign o_cfg_ready = 1'b1;

    swtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swtm_dp #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_now_ms           (s_axis_tdata[31:0]),
        .i_byte_count       (s_axis_tdata[62:32]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_bytes_per_second (bytes_per_second),
        .o_window_bytes     (window_bytes),
        .o_window_span_ms   (window_span_ms),
        .i_cmd              (cmd),
        .o_sts              (sts)
    );

    assign m_axis_tdata = {window_span_ms, window_bytes, bytes_per_second};

endmodule

// ===== bench/throughput_checker.sv =====
// Watches the configuration, report and result channels of the throughput
// meter. Every accepted report beat is run through a cycle-free model of the
// bucket ring, and the reading it yields is queued. Every accepted result beat
// is compared against the oldest queued reading.
module throughput_checker
    import swtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [79:0]           m_axis_tdata,
    output int                    o_readings_owed,
    output int                    o_reading_errors
);

    localparam int SLOTS  = MAX_BUCKETS_DEF;
    localparam int SLOT_W = $clog2(SLOTS);

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [SUM_W-1:0]  total;
        logic [SPAN_W-1:0] span;
    } t_reading;

    // Local copy of the bucket ring and the two registers.
    logic [NOW_W-1:0]    slot_start [SLOTS];
    logic [SUM_W-1:0]    slot_bytes [SLOTS];
    logic [SLOT_W-1:0]   newest_q;
    int unsigned         held_q;
    logic [BWIDTH_W-1:0] width_q;
    logic [WINDOW_W-1:0] window_q;

    t_reading owed_readings[$];
    int       errors;

    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                     input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // Folds one report into the ring, retires stale buckets and returns the
    // reading the block must produce for it.
    function automatic t_reading advance_meter(input logic [NOW_W-1:0] now,
                                               input logic [BYTES_W-1:0] nbytes);
        logic [NOW_W-1:0]  quantum;
        logic [NOW_W-1:0]  start;
        logic [NOW_W-1:0]  age;
        logic [SUM_W-1:0]  total;
        logic [NOW_W-1:0]  span;
        logic [63:0]       rate;
        logic [SLOT_W-1:0] slot;
        logic              scanning;
        int unsigned       kept;
        int unsigned       i;
        t_reading          r;
        // A zero bucket width means no quantization at all.
        quantum = (width_q == '0) ? 32'd1 : NOW_W'(width_q);
        start   = now - (now % quantum);
        if (held_q != 0 && slot_start[newest_q] == start) begin
            slot_bytes[newest_q] = add_clamped(slot_bytes[newest_q], {1'b0, nbytes});
        end else begin
            // Opening a bucket on a full ring overwrites the oldest one.
            newest_q = (held_q != 0) ? newest_q + 1'b1 : '0;
            slot_start[newest_q] = start;
            slot_bytes[newest_q] = {1'b0, nbytes};
            if (held_q < SLOTS) held_q++;
        end
        // Walk from newest to oldest; the first stale bucket ends the walk.
        total    = '0;
        span     = '0;
        kept     = 0;
        scanning = 1'b1;
        for (i = 0; i < held_q && scanning; i++) begin
            slot = newest_q - SLOT_W'(i);
            age  = now - slot_start[slot];
            if (age > NOW_W'(window_q)) begin
                scanning = 1'b0;
            end else begin
                total = add_clamped(total, slot_bytes[slot]);
                span  = age;
                kept++;
            end
        end
        held_q = kept;
        rate = '0;
        if (span != 0) begin
            rate = (64'(total) * 64'(MS_PER_S)) / 64'(span);
            if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
        end
        r.rate  = rate[RATE_W-1:0];
        r.total = total;
        r.span  = span[SPAN_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        if (!i_rst_n) begin
            newest_q = '0;
            held_q   = 0;
            width_q  = BUCKET_WIDTH_RST;
            window_q = WINDOW_RST;
            owed_readings.delete();
            errors = 0;
        end else begin
            // Results first: a beat accepted at this edge cannot belong to a
            // report accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got.rate  = m_axis_tdata[31:0];
                got.total = m_axis_tdata[63:32];
                got.span  = m_axis_tdata[79:64];
                if (owed_readings.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: rate %0d bytes %0d span %0d",
                                 got.rate, got.total, got.span);
                end else begin
                    want = owed_readings.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display(
                                "mismatch exp/act: rate %0d/%0d bytes %0d/%0d span %0d/%0d",
                                want.rate, got.rate, want.total, got.total,
                                want.span, got.span);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BUCKET_WIDTH: width_q  = i_cfg_data[BWIDTH_W-1:0];
                    CFG_WINDOW:       window_q = i_cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                owed_readings.push_back(advance_meter(s_axis_tdata[31:0],
                                                      s_axis_tdata[62:32]));
        end
        o_readings_owed  <= owed_readings.size();
        o_reading_errors <= errors;
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    import swtm_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE       = 200;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;   // now_ms[31:0], byte_count[62:32]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;   // bytes_per_second[31:0],
                                           // window_bytes[63:32],
                                           // window_span_ms[79:64]

    int readings_owed;
    int reading_errors;

    int          stall_pct = 0;
    int          send_idle_pct;
    int          quiet_cycles = 0;
    int unsigned cur_width;
    int unsigned cur_window;
    logic [31:0] clock_ms;

    // Register settings for the random phases, extremes included.
    int unsigned phase_width  [PHASES] = '{100, 1, 1000, 10, 0, 7, 1023, 250};
    int unsigned phase_window [PHASES] = '{2000, 65535, 60000, 500, 1, 3000, 0, 1500};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    sliding_window_throughput_meter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    throughput_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .o_readings_owed  (readings_owed),
        .o_reading_errors (reading_errors)
    );

    // Result side backpressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Ends a run in which no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one report beat and returns at the edge where it is taken.
    task automatic send_report(input logic [31:0] now, input logic [30:0] nbytes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, nbytes, now};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Holds reports back until every owed reading has come out.
    task automatic wait_readings_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (readings_owed != 0) @(posedge i_clk);
    endtask

    // Writes both registers; only called while the block is idle.
    task automatic write_settings(input int unsigned width, input int unsigned window);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BUCKET_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(width);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_WINDOW;
        i_cfg_data  <= CFG_DATA_W'(window);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_width  = width;
        cur_window = window;
    endtask

    task automatic set_idling(input int pattern);
        case (pattern % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 60; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 60; end
            default: begin send_idle_pct = 28; stall_pct <= 28; end
        endcase
    endtask

    function automatic logic [30:0] pick_bytes();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 31'h7FFF_FFFF;
        if (r < 20) return 31'($urandom);
        if (r < 30) return '0;
        return 31'($urandom_range(100000));
    endfunction

    // Mostly reports moving forward inside the bucket grid, with some jumps
    // past the window, some steps back in time and some arbitrary times.
    task automatic run_random_phase(input int count);
        int unsigned quantum;
        int unsigned r;
        int          n;
        quantum  = (cur_width == 0) ? 1 : cur_width;
        clock_ms = $urandom;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 3)
                clock_ms = clock_ms - $urandom_range(3 * quantum + 50, 1);
            else if (r < 8)
                clock_ms = clock_ms + $urandom_range(cur_window + 2 * quantum + 10);
            else if (r < 10)
                clock_ms = $urandom;
            else if (r < 15)
                clock_ms = clock_ms + $urandom_range(3 * quantum);
            else
                clock_ms = clock_ms + $urandom_range(quantum);
            send_report(clock_ms, pick_bytes());
        end
    endtask

    initial begin
        int p;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_BUCKET_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cur_width     = 100;
        cur_window    = 2000;
        set_idling(0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero span, bucket merge and saturation of the bucket,
        // the sum and the rate, expiry, time going back, and wrap of the clock.
        send_report(32'd0, 31'd0);
        send_report(32'd50, 31'h7FFF_FFFF);
        send_report(32'd99, 31'h7FFF_FFFF);
        send_report(32'd99, 31'd2);
        send_report(32'd150, 31'd10);
        send_report(32'd1700, 31'd1000);
        send_report(32'd1999, 31'd5);
        send_report(32'd2150, 31'd3);
        send_report(32'd9000, 31'd77);
        send_report(32'd8000, 31'd5);
        send_report(32'hFFFF_FFFF, 31'h5555_5555);
        send_report(32'h0000_0010, 31'h2AAA_AAAA);
        wait_readings_drained();

        // Zero width and the widest window, right at and just past its edge.
        write_settings(0, 65535);
        send_report(32'd1000, 31'd1);
        send_report(32'd1001, 31'd2);
        send_report(32'd1003, 31'd3);
        send_report(32'd66535, 31'd4);
        send_report(32'd66536, 31'd5);
        wait_readings_drained();

        // Bucket wider than the window: the newest bucket itself can be stale.
        write_settings(1023, 5);
        send_report(32'd1030, 31'd9);
        send_report(32'd2049, 31'd1);
        send_report(32'd2060, 31'd4);
        wait_readings_drained();

        // Zero window: only buckets of age zero count.
        write_settings(1, 0);
        send_report(32'd50, 31'd6);
        send_report(32'd50, 31'd7);
        send_report(32'd51, 31'd8);
        wait_readings_drained();

        for (p = 0; p < PHASES; p++) begin
            write_settings(phase_width[p], phase_window[p]);
            set_idling(p);
            run_random_phase(PHASE_ITEMS);
            wait_readings_drained();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (reading_errors == 0 && readings_owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sliding_window_throughput_meter_core.f =====
hdl/swtm_pkg.sv
hdl/swtm_ctrl.sv
hdl/swtm_dp.sv
hdl/sliding_window_throughput_meter_core.sv
bench/throughput_checker.sv
bench/tb.sv
